/* src/cap_avg_pkg.sv */
// Package for the capacitance averaging and report block.
// Holds shared constants and controller command/status structs.
// No dependencies.
package cap_avg_pkg;

  localparam int unsigned COUNT_WIDTH = 20;
  localparam int unsigned LINE_LEN    = 13;
  localparam int unsigned CHAR_IDX_W  = 4;
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned DIV_CNT_W   = 7;
  localparam int unsigned DIGIT_STEPS = 34;
  localparam int unsigned DIGIT_CNT_W = 6;
  localparam int unsigned BCD_DIGITS  = 10;
  localparam int unsigned ADDR_W      = 4;

  localparam logic [63:0] PF_MAX = 64'd9999999999;

  localparam logic [15:0] REPORT_INTERVAL_RESET = 16'd200;
  localparam logic [15:0] FAST_SCALE_RESET      = 16'd4546;
  localparam logic [19:0] FAST_EXIT_RESET       = 20'd4546;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] REG_INTERVAL  = 4'h0;
  localparam logic [ADDR_W-1:0] REG_SCALE     = 4'h4;
  localparam logic [ADDR_W-1:0] REG_FAST_EXIT = 4'h8;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_P     = 8'h70;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_L     = 8'h4c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef struct packed {
    logic accumulate;  // register a new sample into sum/count
    logic div_start;   // load the divider
    logic div_step;    // one restoring-division step
    logic digit_start; // load the averaged value into the digit splitter
    logic digit_step;  // one digit extraction step
    logic finish;      // update range and clear sum/count
  } cmd_t;

  typedef struct packed {
    logic report_due;
    logic div_done;
    logic digit_done;
  } status_t;

endpackage

/* src/cap_avg_if.sv */
// Valid/ready channel interfaces for the capacitance report block.
// Depends on nothing but plain logic types.
interface cap_avg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] charge_us;
  logic        timed_out;
  logic [31:0] now_ms;
  modport source (output valid, charge_us, timed_out, now_ms, input ready);
  modport sink   (input valid, charge_us, timed_out, now_ms, output ready);
endinterface

interface cap_avg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       range_fast;
  modport source (output valid, text_char, last_char, range_fast, input ready);
  modport sink   (input valid, text_char, last_char, range_fast, output ready);
endinterface

/* src/cap_avg_ctrl.sv */
// Controller state machine for the capacitance report block.
// Depends on cap_avg_pkg; drives datapath commands from status.
module cap_avg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  out_last_i,
  input  cap_avg_pkg::status_t  status_i,
  output cap_avg_pkg::cmd_t     cmd_o,
  output logic                  load_line_o,
  output logic                  emit_o
);
  import cap_avg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MULT   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_DIGIT  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_DRAIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    load_line_o = 1'b0;
    emit_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = S_MULT;
      end
      S_MULT: begin
        cmd_o.accumulate = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.report_due) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.digit_start = 1'b1;
          state_d = S_DIGIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIGIT: begin
        if (status_i.digit_done) begin
          load_line_o  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.digit_step = 1'b1;
        end
      end
      S_EMIT: begin
        // Characters shift out of the line register one item at a time.
        emit_o = 1'b1;
        if (out_valid_i && out_ready_i && out_last_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

/* src/cap_avg_dp.sv */
// Datapath of the capacitance report block: scaling, accumulation,
// serial divider, digit splitter and line register. Depends on cap_avg_pkg.
module cap_avg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [31:0]          charge_us_i,
  input  logic                 timed_out_i,
  input  logic [31:0]          now_ms_i,
  input  logic [15:0]          report_interval_i,
  input  logic [15:0]          fast_scale_i,
  input  logic [19:0]          fast_exit_i,
  input  cap_avg_pkg::cmd_t    cmd_i,
  output cap_avg_pkg::status_t status_o,
  input  logic                 load_line_i,
  input  logic                 emit_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [7:0]           text_char_o,
  output logic                 last_char_o,
  output logic                 range_fast_o
);
  import cap_avg_pkg::*;

  logic                   fast_q;
  logic [63:0]            sum_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [31:0]            last_time_q;
  logic [31:0]            us_q;
  logic                   tout_q;
  logic [31:0]            now_q;
  logic [47:0]            prod_q;

  // Input capture and product register.
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      us_q   <= charge_us_i;
      tout_q <= timed_out_i;
      now_q  <= now_ms_i;
      prod_q <= charge_us_i * fast_scale_i;
    end
  end

  logic [63:0] val;
  logic [64:0] sum_ext;
  logic [31:0] elapsed;
  logic        due;
  assign val     = tout_q ? 64'd0 : (fast_q ? {16'd0, prod_q} : {32'd0, us_q});
  assign sum_ext = {1'b0, sum_q} + {1'b0, val};
  assign elapsed = now_q - last_time_q;
  assign due     = (elapsed > {16'd0, report_interval_i}) || (last_time_q > now_q);
  assign status_o.report_due = due;

  // Restoring divider, one quotient bit per cycle.
  logic [63:0]          quo_q;
  logic [COUNT_WIDTH:0] rem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [COUNT_WIDTH:0] rem_sh;
  logic [COUNT_WIDTH:0] rem_sub;
  assign rem_sh  = {rem_q[COUNT_WIDTH-1:0], quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, count_q};
  assign status_o.div_done = (dcnt_q == DIV_CNT_W'(DIV_STEPS));

  // The clamped average is converted whole to ten BCD digits; the unit then
  // only selects which four integer and two fraction digits are shown.
  logic [63:0] avg_c;
  logic [33:0] pf_c;
  logic [7:0]  unit_c;
  always_comb begin
    avg_c = (count_q == '0) ? 64'd0 : quo_q;
    pf_c  = (avg_c > PF_MAX) ? PF_MAX[33:0] : avg_c[33:0];
    priority if (pf_c > 34'd1000000) unit_c = CHAR_U;
    else if (pf_c > 34'd1000) unit_c = CHAR_N;
    else unit_c = CHAR_P;
  end

  // Double dabble, one input bit per cycle.
  logic [33:0]             bin_q;
  logic [BCD_DIGITS*4-1:0] bcd_q;
  logic [7:0]              unit_q;
  logic [DIGIT_CNT_W-1:0]  bcnt_q;
  logic [BCD_DIGITS*4-1:0] bcd_adj;
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < BCD_DIGITS; i++)
      if (bcd_q[i*4 +: 4] > 4'd4) bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
  end
  assign status_o.digit_done = (bcnt_q == DIGIT_CNT_W'(DIGIT_STEPS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= sum_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[62:0], ~rem_sub[COUNT_WIDTH]};
      rem_q  <= rem_sub[COUNT_WIDTH] ? rem_sh : rem_sub;
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.digit_start) begin
      bin_q  <= pf_c;
      unit_q <= unit_c;
      bcd_q  <= '0;
      bcnt_q <= '0;
    end else if (cmd_i.digit_step) begin
      bcd_q  <= {bcd_adj[BCD_DIGITS*4-2:0], bin_q[33]};
      bin_q  <= {bin_q[32:0], 1'b0};
      bcnt_q <= bcnt_q + 1'b1;
    end
  end

  logic [15:0] int_bcd;
  logic [7:0]  frac_bcd;
  always_comb begin
    priority if (unit_q == CHAR_U) begin
      int_bcd  = bcd_q[39:24];
      frac_bcd = bcd_q[23:16];
    end else if (unit_q == CHAR_N) begin
      int_bcd  = bcd_q[27:12];
      frac_bcd = bcd_q[11:4];
    end else begin
      int_bcd  = bcd_q[15:0];
      frac_bcd = 8'h00;
    end
  end

  // Line register with blanked leading digits.
  logic [LINE_LEN*8-1:0] line_q;
  logic [LINE_LEN*8-1:0] line_c;
  logic [CHAR_IDX_W-1:0] idx_q;
  logic                  lead3, lead2, lead1;
  logic                  vld_q;
  assign lead3 = int_bcd[15:12] == 4'd0;
  assign lead2 = lead3 && int_bcd[11:8] == 4'd0;
  assign lead1 = lead2 && int_bcd[7:4] == 4'd0;
  always_comb begin
    line_c = {
      lead3 ? CHAR_SPACE : CHAR_ZERO | {4'd0, int_bcd[15:12]},
      lead2 ? CHAR_SPACE : CHAR_ZERO | {4'd0, int_bcd[11:8]},
      lead1 ? CHAR_SPACE : CHAR_ZERO | {4'd0, int_bcd[7:4]},
      CHAR_ZERO | {4'd0, int_bcd[3:0]},
      CHAR_DOT,
      CHAR_ZERO | {4'd0, frac_bcd[7:4]},
      CHAR_ZERO | {4'd0, frac_bcd[3:0]},
      CHAR_SPACE, unit_q, CHAR_F, CHAR_SPACE,
      fast_q ? CHAR_L : CHAR_SPACE,
      CHAR_CR};
  end

  logic fire_out;
  assign fire_out     = vld_q && out_ready_i;
  assign out_valid_o  = vld_q;
  assign text_char_o  = line_q[LINE_LEN*8-1 -: 8];
  assign last_char_o  = idx_q == CHAR_IDX_W'(LINE_LEN - 1);
  assign range_fast_o = fast_q;

  always_ff @(posedge clk_i) begin
    if (load_line_i) line_q <= line_c;
    else if (fire_out) line_q <= {line_q[LINE_LEN*8-9:0], 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q      <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      last_time_q <= '0;
      vld_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.accumulate) begin
        sum_q <= sum_ext[64] ? '1 : sum_ext[63:0];
        if (count_q != '1) count_q <= count_q + 1'b1;
      end
      if (cmd_i.div_start) last_time_q <= now_q;
      if (cmd_i.finish) begin
        // Leaving fast range wins over entering it.
        if ({{(32-COUNT_WIDTH){1'b0}}, count_q} > {12'd0, fast_exit_i}) fast_q <= 1'b0;
        else if (count_q == COUNT_WIDTH'(1)) fast_q <= 1'b1;
        sum_q   <= '0;
        count_q <= '0;
      end
      if (load_line_i) begin
        vld_q <= 1'b1;
        idx_q <= '0;
      end else if (fire_out) begin
        idx_q <= idx_q + 1'b1;
        if (last_char_o) vld_q <= 1'b0;
      end
      if (emit_i && !vld_q) vld_q <= 1'b0;
    end
  end

endmodule

/* src/capacitance_average_autorange_display.sv */
// Top level of the capacitance averaging, autorange and report block.
// Depends on cap_avg_pkg, the channel interfaces, cap_avg_ctrl, cap_avg_dp.
//
// in_ch carries one finished charge timing per item (charge_us, timed_out,
// now_ms). An item without a report passes through the accumulate and
// check states, and the next item is taken once the block is back in idle.
// When the report interval has passed, a 64-step restoring divider forms the
// average and a 34-step binary-to-decimal converter builds the digits, before
// the line register is loaded and the first character is offered.
// The 13 character items leave on out_ch, one per cycle while out_ch.ready
// is high, the last flagged by last_char. A report item holds the input
// through the divider, converter and emit states, mostly the divider loop.
// If the receiver stalls, the current character holds and no new input
// item is taken until the carriage return has been delivered.
// Reset clears the range to slow, the sum, count and report time, and loads
// the register defaults. Registers sit on an APB-style port at 4*index.
module capacitance_average_autorange_display (
  input  logic        clk_i,
  input  logic        rst_ni,
  cap_avg_in_if.sink  in_ch,
  cap_avg_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [cap_avg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cap_avg_pkg::*;

  logic [15:0] interval_q;
  logic [15:0] scale_q;
  logic [19:0] fast_exit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= REPORT_INTERVAL_RESET;
      scale_q     <= FAST_SCALE_RESET;
      fast_exit_q <= FAST_EXIT_RESET;
    end else if (wr_en) begin
      unique case (paddr)
        REG_INTERVAL:  interval_q  <= pwdata[15:0];
        REG_SCALE:     scale_q     <= pwdata[15:0];
        REG_FAST_EXIT: fast_exit_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_INTERVAL:  prdata = {16'd0, interval_q};
      REG_SCALE:     prdata = {16'd0, scale_q};
      REG_FAST_EXIT: prdata = {12'd0, fast_exit_q};
      default:       prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t status;
  logic    load_line;
  logic    emit;
  logic    in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  cap_avg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_last_i  (out_ch.last_char),
    .status_i    (status),
    .cmd_o       (cmd),
    .load_line_o (load_line),
    .emit_o      (emit)
  );

  cap_avg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_fire_i         (in_fire),
    .charge_us_i       (in_ch.charge_us),
    .timed_out_i       (in_ch.timed_out),
    .now_ms_i          (in_ch.now_ms),
    .report_interval_i (interval_q),
    .fast_scale_i      (scale_q),
    .fast_exit_i       (fast_exit_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .load_line_i       (load_line),
    .emit_i            (emit),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .text_char_o       (out_ch.text_char),
    .last_char_o       (out_ch.last_char),
    .range_fast_o      (out_ch.range_fast)
  );

`ifndef NO_ASSERTIONS
  // No input item is taken while a report line is still being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted during report");

  // The range flag holds across the characters of one line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && $past(out_ch.valid)) |-> $stable(out_ch.range_fast))
    else $error("range changed within a line");

  // The last character is always the carriage return.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.last_char) |-> (out_ch.text_char == CHAR_CR))
    else $error("last character is not CR");
`endif

endmodule
